// ----- rtl/mpsl_pkg.sv -----
// package: payload types, command codes and default sizes for the pwm slew limiter
`timescale 1ns / 1ps

package mpsl_pkg;

    localparam int C_CHANNELS  = 16;
    localparam int C_FRAC_BITS = 8;
    localparam int C_DUTY_BITS = 16;

    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_INIT = 3'd1;
    localparam logic [2:0] OP_SET  = 3'd2;
    localparam logic [2:0] OP_HALT = 3'd3;
    localparam logic [2:0] OP_READ = 3'd4;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  channel;
        logic [15:0] value;
        logic [23:0] rate;
        logic [15:0] min_duty;
        logic [15:0] max_duty;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [3:0]  out_channel;
        logic [15:0] duty;
        logic        last;
    } t_out_item;

endpackage

// ----- rtl/multichannel_pwm_slew_limiter.sv -----
// top level: channel table in one memory, read-modify-write of one channel per cycle
// result: command latched, its channel read into r_rdata, then registered in r_out
// tick: walks every channel, reading the next one from memory while the current
//   one is written back; every other command touches a single channel
// one command at a time; a tick or a read stalls while the output register is not taken
// reset: synchronous, active low; per-entry valid bits clear at once and an entry not
//   yet written reads as all zero, so no clearing pass is needed
`timescale 1ns / 1ps

module multichannel_pwm_slew_limiter
    import mpsl_pkg::*;
#(
    parameter int CHANNELS  = C_CHANNELS,
    parameter int FRAC_BITS = C_FRAC_BITS,
    parameter int DUTY_BITS = C_DUTY_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam int NCH   = (CHANNELS > 16) ? 16 : CHANNELS;
    localparam int AW    = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int POS_W = DUTY_BITS + FRAC_BITS;
    localparam int RATE_W = 24;
    localparam int CW    = (POS_W > RATE_W) ? POS_W : RATE_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  tgt;
        logic [RATE_W-1:0] rate;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
    } t_word;

    function automatic logic [POS_W-1:0] to_fixed(input logic [15:0] counts);
        return POS_W'(counts[DUTY_BITS-1:0]) << FRAC_BITS;
    endfunction

    function automatic logic [15:0] duty_of(input logic [POS_W-1:0] pos);
        return 16'(pos >> FRAC_BITS);
    endfunction

    logic              r_state, n_state;
    t_in_item          r_cmd;
    logic [AW-1:0]     r_ch, n_ch;
    logic              r_ch_ok;
    t_word             r_mem [NCH];
    logic [NCH-1:0]    r_vld;
    t_word             r_rdata;
    logic              r_rd_vld;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              accept, out_free, needs_out, ex_go, is_last;
    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr;
    logic              in_ch_ok;
    t_word             cur, nxt;
    logic [POS_W-1:0]  moved;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_free    = !r_out_valid || i_out_ready;
    assign in_ch_ok    = (32'(i_in.channel) < NCH);
    assign needs_out   = (r_cmd.opcode == OP_TICK) || (r_cmd.opcode == OP_READ);
    assign ex_go       = (r_state == S_EXEC) && (!needs_out || out_free);
    assign is_last     = (r_ch == AW'(NCH - 1));
    assign cur         = r_rd_vld ? r_rdata : '0;

    // step toward the target without passing it, clamp on the side of travel
    always_comb begin
        logic [CW-1:0]    p, t, r, d, stp;
        logic [POS_W-1:0] q;
        p = CW'(cur.pos);
        t = CW'(cur.tgt);
        r = CW'(cur.rate);
        q = cur.pos;
        if (p > t) begin
            d   = p - t;
            stp = (r < d) ? r : d;
            q   = POS_W'(p - stp);
            if (q < cur.lo) begin
                q = cur.lo;
            end
        end else if (p < t) begin
            d   = t - p;
            stp = (r < d) ? r : d;
            q   = POS_W'(p + stp);
            if (q > cur.hi) begin
                q = cur.hi;
            end
        end else begin
            d   = '0;
            stp = '0;
        end
        moved = q;
    end

    always_comb begin
        nxt = cur;
        unique case (r_cmd.opcode)
            OP_TICK: begin
                nxt.pos = moved;
            end
            OP_INIT: begin
                nxt.pos = to_fixed(r_cmd.value);
                nxt.lo  = to_fixed(r_cmd.min_duty);
                nxt.hi  = to_fixed(r_cmd.max_duty);
            end
            OP_SET: begin
                nxt.rate = r_cmd.rate;
                nxt.tgt  = to_fixed(r_cmd.value);
            end
            OP_HALT: begin
                nxt.pos  = to_fixed(r_cmd.value);
                nxt.tgt  = to_fixed(r_cmd.value);
                nxt.rate = '0;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

    assign wr_en = ex_go && ((r_cmd.opcode == OP_TICK) ||
                   (r_ch_ok && ((r_cmd.opcode == OP_INIT) || (r_cmd.opcode == OP_SET) ||
                                (r_cmd.opcode == OP_HALT))));

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        rd_en   = 1'b0;
        rd_addr = r_ch;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    rd_en = 1'b1;
                    if (i_in.opcode == OP_TICK || !in_ch_ok) begin
                        rd_addr = '0;
                    end else begin
                        rd_addr = i_in.channel[AW-1:0];
                    end
                    n_ch    = rd_addr;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (ex_go) begin
                    // next channel is read while this one is written back
                    if (r_cmd.opcode == OP_TICK && !is_last) begin
                        rd_en   = 1'b1;
                        rd_addr = r_ch + 1'b1;
                        n_ch    = rd_addr;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[r_ch] <= nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_ch        <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            if (rd_en) begin
                r_rd_vld <= r_vld[rd_addr];
            end
            if (wr_en) begin
                r_vld[r_ch] <= 1'b1;
            end
            if (ex_go && needs_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_in;
            r_ch_ok <= in_ch_ok;
        end
        if (ex_go && needs_out) begin
            if (r_cmd.opcode == OP_TICK) begin
                r_out.kind        <= KIND_TICK;
                r_out.out_channel <= 4'(r_ch);
                r_out.duty        <= duty_of(moved);
                r_out.last        <= is_last;
            end else begin
                r_out.kind        <= KIND_READ;
                r_out.out_channel <= r_cmd.channel;
                r_out.duty        <= r_ch_ok ? duty_of(cur.pos) : 16'd0;
                r_out.last        <= 1'b1;
            end
        end
    end

endmodule
